// ----- rtl/brb_pkg.sv -----
// Shared constants, operation codes and the result record of the byte ring buffer.
package brb_pkg;

    localparam int DEPTH_DEF     = 4096;
    localparam int MAX_BURST_DEF = 64;

    localparam int BYTE_W   = 8;
    localparam int CNT_W    = 13;
    localparam int KIND_W   = 3;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 40;

    localparam logic [KIND_W-1:0] KIND_WRITE   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_READ    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CONSUME = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REWIND  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_FORWARD = 3'd5;
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd6;

    typedef struct packed {
        logic [CNT_W-1:0]  fill;
        logic [CNT_W-1:0]  moved;
        logic              last;
        logic              byte_valid;
        logic [BYTE_W-1:0] byte_out;
    } res_t;

endpackage

// ----- rtl/brb_ram.sv -----
// Generic single-clock RAM, one write port and one registered read port.
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/brb_out_q.sv -----
// Two-entry result queue that decouples the buffer core from the master side.
module brb_out_q
    import brb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  res_t       push_data,
    input  logic       pop,
    output logic       out_valid,
    output res_t       out_data,
    output logic [1:0] count
);

    res_t       q_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;
    logic       do_pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = q_reg[rptr_reg];
    assign count     = cnt_reg;
    assign do_pop    = pop && out_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (do_pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            if (push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (!push && do_pop)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

// ----- rtl/byte_ring_buffer.sv -----
// Top level of the byte ring buffer: index and fill control around one byte store.
//
// Requests enter on the s_ group: s_tuser carries the kind (write, read, peek,
// consume, rewind, forward, clear), s_tdata the byte to store and the length.
// Results leave on the m_ group, m_tlast on the final result of each request,
// m_tuser flagging a returned byte. cfg_we/cfg_wdata set the capacity in use
// and empty the buffer; write it only while the block is idle.
// A request with a single result can be taken on the master side in the cycle
// after acceptance, so writes, consumes and the like stream at one request per
// cycle while the master side keeps taking results. A read or peek of N bytes
// issues one store read per cycle through the registered read port while the
// result queue has room: the first byte passes the burst state register, the store
// read register and the result queue, then bytes follow one per cycle while the
// queue has room. s_tready stays low until the last store read has returned.
// After reset the store is zeroed one entry per cycle, during
// which s_tready is low. A two-entry result queue sits before the master side:
// when the receiver stalls, the queue fills and the block holds its request
// side and its store reads until room frees up.
module byte_ring_buffer
    import brb_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int MAX_BURST = MAX_BURST_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CNT_W-1:0]    cfg_wdata,   // capacity
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,     // byte_in [7:0], length [20:8], zero pad
    input  logic [KIND_W-1:0]   s_tuser,     // kind [2:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,     // byte_out [7:0], moved [20:8], fill [33:21]
    output logic                m_tlast,
    output logic                m_tuser      // byte_valid [0]
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CAPW = $clog2(DEPTH + 1);
    localparam int XW   = ((CAPW > CNT_W) ? CAPW : CNT_W) + 1;
    localparam int BW   = $clog2(MAX_BURST + 1);

    typedef enum logic {ST_IDLE, ST_BURST} state_t;

    function automatic logic [AW-1:0] idx_adv(logic [AW-1:0] idx, logic [XW-1:0] amt,
                                              logic [XW-1:0] cap);
        logic [XW-1:0] s;
        s = XW'(idx) + amt;
        if (s >= cap)
        begin
            s = s - cap;
        end
        return AW'(s);
    endfunction

    function automatic logic [AW-1:0] idx_ret(logic [AW-1:0] idx, logic [XW-1:0] amt,
                                              logic [XW-1:0] cap);
        logic [XW-1:0] s;
        if (XW'(idx) < amt)
        begin
            s = XW'(idx) + cap - amt;
        end
        else
        begin
            s = XW'(idx) - amt;
        end
        return AW'(s);
    endfunction

    state_t           state_reg,      state_next;
    logic [AW-1:0]    widx_reg,       widx_next;
    logic [AW-1:0]    ridx_reg,       ridx_next;
    logic [CAPW-1:0]  held_reg,       held_next;
    logic [CAPW-1:0]  cap_reg,        cap_next;
    logic             clearing_reg,   clearing_next;
    logic [AW-1:0]    clr_addr_reg,   clr_addr_next;
    logic [BW-1:0]    left_reg,       left_next;
    logic [AW-1:0]    baddr_reg,      baddr_next;
    logic [CNT_W-1:0] bamt_reg,       bamt_next;
    logic [CNT_W-1:0] bfill_reg,      bfill_next;
    logic             infl_reg,       infl_next;
    logic             infl_last_reg,  infl_last_next;

    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] byte_in;
    logic [CNT_W-1:0]  length;
    logic              acc;
    logic              pop;
    logic              issue;
    logic [2:0]        pending;
    logic [XW-1:0]     held_x, cap_x, amt_x, amt_b, fill_after, cfg_x, cfg_eff;
    logic [1:0]        q_cnt;
    logic              q_valid;
    res_t              q_data;
    logic              push;
    res_t              push_data;
    logic              single;
    logic [CNT_W-1:0]  res_moved, res_fill;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic [BYTE_W-1:0] ram_rdata;

    assign kind    = s_tuser;
    assign byte_in = s_tdata[BYTE_W-1:0];
    assign length  = s_tdata[BYTE_W +: CNT_W];

    assign s_tready = (state_reg == ST_IDLE) && !clearing_reg && !infl_reg && (q_cnt != 2'd2);
    assign acc      = s_tvalid && s_tready;
    assign pop      = q_valid && m_tready;

    // read only when the returning byte is sure to find room in the queue
    assign pending = 3'(q_cnt) + 3'(infl_reg);
    assign issue   = (state_reg == ST_BURST) &&
                     ((pending < 3'd2) || ((pending == 3'd2) && pop));

    assign held_x = XW'(held_reg);
    assign cap_x  = XW'(cap_reg);
    assign amt_x  = (held_x < XW'(length)) ? held_x : XW'(length);
    assign amt_b  = (amt_x < XW'(MAX_BURST)) ? amt_x : XW'(MAX_BURST);
    assign fill_after = (kind == KIND_READ) ? (held_x - amt_b) : held_x;

    always_comb
    begin
        cfg_x = XW'(cfg_wdata);
        if (cfg_x == XW'(0))
        begin
            cfg_eff = XW'(1);
        end
        else if (cfg_x > XW'(DEPTH))
        begin
            cfg_eff = XW'(DEPTH);
        end
        else
        begin
            cfg_eff = cfg_x;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        widx_next      = widx_reg;
        ridx_next      = ridx_reg;
        held_next      = held_reg;
        cap_next       = cap_reg;
        clearing_next  = clearing_reg;
        clr_addr_next  = clr_addr_reg;
        left_next      = left_reg;
        baddr_next     = baddr_reg;
        bamt_next      = bamt_reg;
        bfill_next     = bfill_reg;
        infl_next      = issue;
        infl_last_next = (left_reg == BW'(1));
        single         = 1'b0;
        res_moved      = '0;
        res_fill       = CNT_W'(held_reg);
        ram_we         = 1'b0;
        ram_waddr      = widx_reg;
        ram_wdata      = byte_in;

        if (clearing_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clearing_next = 1'b0;
            end
        end

        if (issue)
        begin
            left_next  = left_reg - BW'(1);
            baddr_next = idx_adv(baddr_reg, XW'(1), cap_x);
            if (left_reg == BW'(1))
            begin
                state_next = ST_IDLE;
            end
        end

        if (acc)
        begin
            single = 1'b1;
            unique case (kind)
                KIND_WRITE:
                begin
                    if (held_x < cap_x)
                    begin
                        ram_we    = 1'b1;
                        widx_next = idx_adv(widx_reg, XW'(1), cap_x);
                        held_next = held_reg + CAPW'(1);
                        res_moved = CNT_W'(1);
                        res_fill  = CNT_W'(held_x + XW'(1));
                    end
                end
                KIND_READ, KIND_PEEK:
                begin
                    res_fill = CNT_W'(fill_after);
                    if (amt_b != XW'(0))
                    begin
                        single     = 1'b0;
                        state_next = ST_BURST;
                        left_next  = BW'(amt_b);
                        baddr_next = ridx_reg;
                        bamt_next  = CNT_W'(amt_b);
                        bfill_next = CNT_W'(fill_after);
                        if (kind == KIND_READ)
                        begin
                            ridx_next = idx_adv(ridx_reg, amt_b, cap_x);
                            held_next = CAPW'(fill_after);
                        end
                    end
                end
                KIND_CONSUME:
                begin
                    ridx_next = idx_adv(ridx_reg, amt_x, cap_x);
                    held_next = CAPW'(held_x - amt_x);
                    res_moved = CNT_W'(amt_x);
                    res_fill  = CNT_W'(held_x - amt_x);
                end
                KIND_REWIND:
                begin
                    widx_next = idx_ret(widx_reg, amt_x, cap_x);
                    ridx_next = idx_ret(ridx_reg, amt_x, cap_x);
                    res_moved = CNT_W'(amt_x);
                end
                KIND_FORWARD:
                begin
                    widx_next = idx_adv(widx_reg, amt_x, cap_x);
                    ridx_next = idx_adv(ridx_reg, amt_x, cap_x);
                    res_moved = CNT_W'(amt_x);
                end
                KIND_CLEAR:
                begin
                    widx_next = '0;
                    ridx_next = '0;
                    held_next = '0;
                    res_fill  = '0;
                end
                default:
                begin
                    // unused kind: report only
                end
            endcase
        end

        // capacity change empties the buffer, store contents stay
        if (cfg_we)
        begin
            cap_next  = CAPW'(cfg_eff);
            widx_next = '0;
            ridx_next = '0;
            held_next = '0;
        end
    end

    always_comb
    begin
        push = single || infl_reg;
        if (infl_reg)
        begin
            push_data.byte_out   = ram_rdata;
            push_data.byte_valid = 1'b1;
            push_data.last       = infl_last_reg;
            push_data.moved      = bamt_reg;
            push_data.fill       = bfill_reg;
        end
        else
        begin
            push_data.byte_out   = '0;
            push_data.byte_valid = 1'b0;
            push_data.last       = 1'b1;
            push_data.moved      = res_moved;
            push_data.fill       = res_fill;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            widx_reg      <= '0;
            ridx_reg      <= '0;
            held_reg      <= '0;
            cap_reg       <= CAPW'(DEPTH);
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            left_reg      <= '0;
            infl_reg      <= 1'b0;
            infl_last_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            widx_reg      <= widx_next;
            ridx_reg      <= ridx_next;
            held_reg      <= held_next;
            cap_reg       <= cap_next;
            clearing_reg  <= clearing_next;
            clr_addr_reg  <= clr_addr_next;
            left_reg      <= left_next;
            infl_reg      <= infl_next;
            infl_last_reg <= infl_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        baddr_reg <= baddr_next;
        bamt_reg  <= bamt_next;
        bfill_reg <= bfill_next;
    end

    brb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issue),
        .raddr (baddr_reg),
        .rdata (ram_rdata)
    );

    brb_out_q u_out_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (m_tready),
        .out_valid (q_valid),
        .out_data  (q_data),
        .count     (q_cnt)
    );

    assign m_tvalid = q_valid;
    assign m_tdata  = {{(M_DATA_W - BYTE_W - 2*CNT_W){1'b0}},
                       q_data.fill, q_data.moved, q_data.byte_out};
    assign m_tlast  = q_data.last;
    assign m_tuser  = q_data.byte_valid;

endmodule
